/* rtl/core/trb_pkg.sv */
// Shared types, operation codes and size constants for the trace ring buffer.
package trb_pkg;

	localparam int TRB_DEPTH = 64;

	localparam int SEV_W = 3;
	localparam int CAT_W = 16;
	localparam int DOM_W = 16;
	localparam int PAY_W = 64;
	localparam int OP_W  = 3;

	localparam logic [OP_W-1:0] OP_PUSH      = 3'd0;
	localparam logic [OP_W-1:0] OP_DUMP_ALL  = 3'd1;
	localparam logic [OP_W-1:0] OP_DUMP_FILT = 3'd2;
	localparam logic [OP_W-1:0] OP_DUMP_DOM  = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;
	localparam logic [OP_W-1:0] OP_COUNT     = 3'd5;

	typedef struct packed {
		logic [SEV_W-1:0] sev;
		logic [CAT_W-1:0] cat;
		logic [DOM_W-1:0] dom;
		logic [PAY_W-1:0] pay;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic push;
		logic clear;
		logic load;
		logic walk;
		logic emit_final;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic walk_done;
		logic out_free;
	} sts_t;

endpackage

/* rtl/core/trb_in_if.sv */
// Request channel: valid/ready handshake carrying one trace buffer request.
interface trb_in_if
	import trb_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  op;
	logic [SEV_W-1:0] severity;
	logic [CAT_W-1:0] category;
	logic [DOM_W-1:0] domain;
	logic [PAY_W-1:0] payload;

	modport source (output valid, op, severity, category, domain, payload, input ready);
	modport sink (input valid, op, severity, category, domain, payload, output ready);
endinterface

/* rtl/core/trb_out_if.sv */
// Result channel: valid/ready handshake carrying one trace buffer result.
interface trb_out_if
	import trb_pkg::*;
#(
	parameter int CNT_W = $clog2(TRB_DEPTH + 1)
) ();
	logic             valid;
	logic             ready;
	logic             has_entry;
	logic             last;
	logic [SEV_W-1:0] entry_severity;
	logic [CAT_W-1:0] entry_category;
	logic [DOM_W-1:0] entry_domain;
	logic [PAY_W-1:0] entry_payload;
	logic [CNT_W-1:0] stored_count;

	modport source (output valid, has_entry, last, entry_severity, entry_category,
		entry_domain, entry_payload, stored_count, input ready);
	modport sink (input valid, has_entry, last, entry_severity, entry_category,
		entry_domain, entry_payload, stored_count, output ready);
endinterface

/* rtl/core/trace_ring_buffer_filtered_dump.sv */
// Top level of the overwriting circular trace buffer with filtered dump.
// Pushes and clears are accepted back to back, one per cycle, while no dump or query is in progress.
// A count query holds the request side busy until its result is written to the result register.
// A dump walks the held entries one per cycle through the single memory read port,
// except while a hit waits on a full result register, which stalls the walk.
// Reset clears head, count and the walk and result state; the entry memory has no clearing pass.
module trace_ring_buffer_filtered_dump
	import trb_pkg::*;
#(
	parameter int DEPTH = TRB_DEPTH
) (
	input logic        clk,
	input logic        arst_n,
	trb_in_if.sink     req,
	trb_out_if.source  rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          cmd;
	sts_t          sts;
	entry_t        rsp_entry;
	logic [CW-1:0] rsp_count;

	trb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_op    (req.op),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	trb_dp #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_op        (req.op),
		.req_severity  (req.severity),
		.req_category  (req.category),
		.req_domain    (req.domain),
		.req_payload   (req.payload),
		.rsp_valid     (rsp.valid),
		.rsp_ready     (rsp.ready),
		.rsp_has_entry (rsp.has_entry),
		.rsp_last      (rsp.last),
		.rsp_entry     (rsp_entry),
		.rsp_count     (rsp_count)
	);

	assign rsp.entry_severity = rsp_entry.sev;
	assign rsp.entry_category = rsp_entry.cat;
	assign rsp.entry_domain   = rsp_entry.dom;
	assign rsp.entry_payload  = rsp_entry.pay;
	assign rsp.stored_count   = rsp_count;

endmodule

/* rtl/core/trb_ctrl.sv */
// Controller state machine: request decode and sequencing of dumps and queries.
module trb_ctrl
	import trb_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic [OP_W-1:0] req_op,
	output logic            req_ready,
	input  sts_t            sts,
	output cmd_t            cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_FINAL = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req_op)
						OP_PUSH:  cmd.push = 1'b1;
						OP_CLEAR: cmd.clear = 1'b1;
						OP_DUMP_ALL, OP_DUMP_FILT, OP_DUMP_DOM: begin
							cmd.load = 1'b1;
							state_d  = ST_WALK;
						end
						// A count query is a dump that finds nothing to walk.
						OP_COUNT: begin
							cmd.load = 1'b1;
							state_d  = ST_FINAL;
						end
						default: ;
					endcase
				end
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_done) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				if (sts.out_free) begin
					cmd.emit_final = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/core/trb_dp.sv */
// Datapath: entry memory, head and count, dump walk pipeline and result register.
module trb_dp
	import trb_pkg::*;
#(
	parameter int DEPTH = TRB_DEPTH,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic [OP_W-1:0]  req_op,
	input  logic [SEV_W-1:0] req_severity,
	input  logic [CAT_W-1:0] req_category,
	input  logic [DOM_W-1:0] req_domain,
	input  logic [PAY_W-1:0] req_payload,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output logic             rsp_has_entry,
	output logic             rsp_last,
	output entry_t           rsp_entry,
	output logic [CW-1:0]    rsp_count
);

	entry_t mem [DEPTH];

	logic [AW-1:0]    head_q;
	logic [CW-1:0]    cnt_q;
	logic [OP_W-1:0]  op_q;
	logic [SEV_W-1:0] sev_q;
	logic [CAT_W-1:0] cat_q;
	logic [DOM_W-1:0] dom_q;
	logic [AW-1:0]    idx_q;
	logic [CW-1:0]    rem_q;
	logic             rdv_q;
	entry_t           rd_q;
	logic             pend_v_q;
	entry_t           pend_q;
	logic             out_v_q;
	logic             out_has_q;
	logic             out_last_q;
	entry_t           out_ent_q;
	logic [CW-1:0]    out_cnt_q;

	logic pass;
	logic hit;
	logic fwd;
	logic adv;
	logic issue;
	logic full;

	assign full = (cnt_q == CW'(DEPTH));

	always_comb begin
		unique case (op_q)
			OP_DUMP_ALL:  pass = 1'b1;
			OP_DUMP_FILT: pass = (rd_q.sev >= sev_q) && (cat_q == '0 || rd_q.cat == cat_q);
			OP_DUMP_DOM:  pass = (rd_q.dom == dom_q);
			default:      pass = 1'b0;
		endcase
	end

	// A hit is held back one match so that the final one can be flagged last.
	// The walk stalls only when a hit must push the held entry into a full output.
	assign sts.out_free  = !out_v_q || rsp_ready;
	assign hit           = rdv_q && pass;
	assign fwd           = hit && pend_v_q;
	assign adv           = cmd.walk && (!fwd || sts.out_free);
	assign issue         = adv && (rem_q != '0);
	assign sts.walk_done = (rem_q == '0) && !rdv_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[head_q] <= '{sev: req_severity, cat: req_category, dom: req_domain,
				pay: req_payload};
		end
		if (issue) begin
			rd_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req_op;
			sev_q <= req_severity;
			cat_q <= req_category;
			dom_q <= req_domain;
		end
		if (adv && hit) begin
			pend_q <= rd_q;
		end
		if (adv && fwd) begin
			out_ent_q <= pend_q;
		end else if (cmd.emit_final) begin
			out_ent_q <= pend_v_q ? pend_q : '0;
		end
		if ((adv && fwd) || cmd.emit_final) begin
			out_cnt_q <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			cnt_q      <= '0;
			idx_q      <= '0;
			rem_q      <= '0;
			rdv_q      <= 1'b0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			out_has_q  <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				head_q <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
				if (!full) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.clear) begin
				head_q <= '0;
				cnt_q  <= '0;
			end
			if (cmd.load) begin
				// A full buffer starts at its oldest entry, which the head points to.
				idx_q    <= full ? head_q : '0;
				rem_q    <= cnt_q;
				rdv_q    <= 1'b0;
				pend_v_q <= 1'b0;
			end else if (adv) begin
				if (issue) begin
					idx_q <= (idx_q == AW'(DEPTH - 1)) ? '0 : idx_q + 1'b1;
					rem_q <= rem_q - 1'b1;
				end
				rdv_q <= issue;
				if (hit) begin
					pend_v_q <= 1'b1;
				end
			end
			if (adv && fwd) begin
				out_v_q    <= 1'b1;
				out_has_q  <= 1'b1;
				out_last_q <= 1'b0;
			end else if (cmd.emit_final) begin
				out_v_q    <= 1'b1;
				out_has_q  <= pend_v_q;
				out_last_q <= 1'b1;
			end else if (rsp_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign rsp_valid     = out_v_q;
	assign rsp_has_entry = out_has_q;
	assign rsp_last      = out_last_q;
	assign rsp_entry     = out_ent_q;
	assign rsp_count     = out_cnt_q;

endmodule
